@@ rtl/core/char_lcd_double_buffer_refresh_macros.svh @@
// Assertion macros for the checker file.
// Each one samples on the rising edge of clock and is off while reset is high.
`ifndef CHAR_LCD_DOUBLE_BUFFER_REFRESH_MACROS_SVH
`define CHAR_LCD_DOUBLE_BUFFER_REFRESH_MACROS_SVH

// Same-cycle implication.
`define CLDB_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cldb assertion failed");

// Next-cycle implication.
`define CLDB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cldb assertion failed");

`endif

@@ rtl/core/cldb_pkg.sv @@
package cldb_pkg;

   // request opcodes (code 3 is unused and rejected)
   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_COMMIT = 2'd2
   } op_type;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_IDLE_PERIOD = 1'b0,
      CSR_BUSY_PERIOD = 1'b1
   } csr_index_type;

   localparam logic [7:0] IDLE_PERIOD_RESET = 8'd128;
   localparam logic [7:0] BUSY_PERIOD_RESET = 8'd8;

   // set DDRAM address 0 (cursor home)
   localparam logic [7:0] HOME_CMD = 8'h80;

   // refresh sequencer states
   typedef enum logic [2:0] {
      SEQ_IDLE    = 3'd0,
      SEQ_CMD_HI1 = 3'd1,
      SEQ_CMD_LO1 = 3'd2,
      SEQ_CMD_HI2 = 3'd3,
      SEQ_CMD_LO2 = 3'd4,
      SEQ_CMD_END = 3'd5,
      SEQ_DATA_HI = 3'd6,
      SEQ_DATA_LO = 3'd7
   } seq_state_type;

   // one response item
   typedef struct packed {
      logic       accepted;
      logic       rs_line;
      logic       enable_line;
      logic [3:0] data_nibble;
      logic [7:0] tick_period;
      logic       refresh_busy;
   } rsp_item_type;

endpackage

@@ rtl/core/cldb_if.sv @@
// Request channel
interface cldb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [6:0] cell_address;
   logic [7:0] char_value;

   modport source (output valid, output op, output cell_address, output char_value,
                   input ready);
   modport sink (input valid, input op, input cell_address, input char_value,
                 output ready);
endinterface

// Response channel
interface cldb_rsp_if;
   logic       valid;
   logic       ready;
   logic       accepted;
   logic       rs_line;
   logic       enable_line;
   logic [3:0] data_nibble;
   logic [7:0] tick_period;
   logic       refresh_busy;

   modport source (output valid, output accepted, output rs_line, output enable_line,
                   output data_nibble, output tick_period, output refresh_busy,
                   input ready);
   modport sink (input valid, input accepted, input rs_line, input enable_line,
                 input data_nibble, input tick_period, input refresh_busy,
                 output ready);
endinterface

// Configuration write channel
interface cldb_csr_if;
   import cldb_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [7:0]                 data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/cldb_frame_ram.sv @@
// Frame store for both buffers: one write port, one registered read port.
// A write and a read to the same entry in one cycle return the new data.
module cldb_frame_ram #(
   parameter int  ROWS = 4,
   parameter int  COLS = 20,
   localparam int DEPTH = 2 * ROWS * COLS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // write-first read
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/cldb_seq.sv @@
// Refresh sequencer and buffer bookkeeping. Applies one request per cycle on which
// req_fire is high and produces its response item. The frame read address is issued
// from the next read position, so the registered byte is ready when a data tick arrives.
module cldb_seq #(
   parameter int  ROWS = 4,
   parameter int  COLS = 20,
   localparam int ADDR_W = $clog2(2 * ROWS * COLS)
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_fire,
   input  logic [1:0]                               op,
   input  logic [6:0]                               cell_address,
   input  logic [7:0]                               char_value,
   input  logic                                     csr_we,
   input  logic [cldb_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [7:0]                               csr_data,
   output logic                                     ram_wr_en,
   output logic [ADDR_W-1:0]                        ram_wr_addr,
   output logic [7:0]                               ram_wr_data,
   output logic [ADDR_W-1:0]                        ram_rd_addr,
   input  logic [7:0]                               ram_rd_data,
   output cldb_pkg::rsp_item_type                   rsp_item
);
   import cldb_pkg::*;

   localparam int                FRAME_CELLS = ROWS * COLS;
   localparam int                IDX_W = $clog2(FRAME_CELLS + 1);
   localparam logic [IDX_W-1:0]  END_IDX = IDX_W'(FRAME_CELLS);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(FRAME_CELLS - 1);
   localparam logic [ADDR_W-1:0] FRAME_BASE = ADDR_W'(FRAME_CELLS);

   seq_state_type    state_ff, state_in;
   logic [1:0]       free_ff, free_in;
   logic [1:0]       pending_ff, pending_in;
   logic             disp_ff, disp_in;
   logic             fill_ff, fill_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             high_ff, high_in;
   logic             rs_ff, rs_in;
   logic             en_ff, en_in;
   logic [3:0]       data_ff, data_in;
   logic             rate_ff, rate_in;
   logic [7:0]       idle_period_ff, idle_period_in;
   logic [7:0]       busy_period_ff, busy_period_in;

   logic             is_tick;
   logic             is_write;
   logic             is_commit;
   logic             fill_free;
   logic             other_pending;
   logic             frame_done;
   logic [IDX_W-1:0] rd_idx;

   // request decode
   assign is_tick       = req_fire && (op == OP_TICK);
   assign is_write      = req_fire && (op == OP_WRITE);
   assign is_commit     = req_fire && (op == OP_COMMIT);
   assign fill_free     = free_ff[fill_ff];
   assign other_pending = pending_ff[~disp_ff];
   assign frame_done    = (idx_ff >= END_IDX) || other_pending;

   // next state
   always_comb begin
      state_in = state_ff;
      if (is_tick) begin
         case (state_ff)
            SEQ_IDLE:    state_in = SEQ_IDLE;
            SEQ_CMD_HI1: state_in = SEQ_CMD_LO1;
            SEQ_CMD_LO1: state_in = SEQ_CMD_HI2;
            SEQ_CMD_HI2: state_in = SEQ_CMD_LO2;
            SEQ_CMD_LO2: state_in = SEQ_CMD_END;
            SEQ_CMD_END: state_in = SEQ_DATA_HI;
            SEQ_DATA_HI: state_in = SEQ_DATA_LO;
            SEQ_DATA_LO: begin
               // finish the current byte before leaving the frame
               if (frame_done && high_ff) begin
                  state_in = other_pending ? SEQ_CMD_HI1 : SEQ_IDLE;
               end else begin
                  state_in = SEQ_DATA_HI;
               end
            end
            default:     state_in = SEQ_IDLE;
         endcase
      end else if (is_commit && fill_free && (state_ff == SEQ_IDLE)) begin
         state_in = SEQ_CMD_HI1;
      end
   end

   // line levels, buffer flags and pointers
   always_comb begin
      free_in        = free_ff;
      pending_in     = pending_ff;
      disp_in        = disp_ff;
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      high_in        = high_ff;
      rs_in          = rs_ff;
      en_in          = en_ff;
      data_in        = data_ff;
      rate_in        = rate_ff;
      if (is_tick) begin
         case (state_ff)
            SEQ_IDLE: begin
               rate_in = 1'b0;
            end
            SEQ_CMD_HI1: begin
               rate_in = 1'b1;
               rs_in   = 1'b0;
               data_in = HOME_CMD[7:4];
               en_in   = 1'b1;
            end
            SEQ_CMD_LO1: begin
               en_in = 1'b0;
            end
            SEQ_CMD_HI2: begin
               data_in = HOME_CMD[3:0];
               en_in   = 1'b1;
            end
            SEQ_CMD_LO2: begin
               en_in = 1'b0;
            end
            SEQ_CMD_END: begin
               rs_in = 1'b1;
            end
            SEQ_DATA_HI: begin
               if (high_ff) begin
                  data_in = ram_rd_data[7:4];
               end else begin
                  data_in = ram_rd_data[3:0];
                  if (idx_ff < END_IDX) begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               high_in = ~high_ff;
               en_in   = 1'b1;
            end
            SEQ_DATA_LO: begin
               en_in = 1'b0;
               // release the shown buffer and swap
               if (frame_done && high_ff) begin
                  free_in[disp_ff]    = 1'b1;
                  pending_in[disp_ff] = 1'b0;
                  disp_in             = ~disp_ff;
                  idx_in              = '0;
                  high_in             = 1'b1;
               end
            end
            default: begin
               en_in = en_ff;
            end
         endcase
      end else if (is_commit && fill_free) begin
         free_in[fill_ff]    = 1'b0;
         pending_in[fill_ff] = 1'b1;
         fill_in             = ~fill_ff;
      end
   end

   // configuration registers
   always_comb begin
      idle_period_in = idle_period_ff;
      busy_period_in = busy_period_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IDLE_PERIOD: idle_period_in = csr_data;
            CSR_BUSY_PERIOD: busy_period_in = csr_data;
            default:         idle_period_in = idle_period_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SEQ_IDLE;
         free_ff        <= 2'b11;
         pending_ff     <= 2'b00;
         disp_ff        <= 1'b0;
         fill_ff        <= 1'b0;
         idx_ff         <= '0;
         high_ff        <= 1'b1;
         rs_ff          <= 1'b1;
         en_ff          <= 1'b0;
         data_ff        <= 4'd0;
         rate_ff        <= 1'b0;
         idle_period_ff <= IDLE_PERIOD_RESET;
         busy_period_ff <= BUSY_PERIOD_RESET;
      end else begin
         state_ff       <= state_in;
         free_ff        <= free_in;
         pending_ff     <= pending_in;
         disp_ff        <= disp_in;
         fill_ff        <= fill_in;
         idx_ff         <= idx_in;
         high_ff        <= high_in;
         rs_ff          <= rs_in;
         en_ff          <= en_in;
         data_ff        <= data_in;
         rate_ff        <= rate_in;
         idle_period_ff <= idle_period_in;
         busy_period_ff <= busy_period_in;
      end
   end

   // frame writes go to the fill buffer
   assign ram_wr_en   = is_write && fill_free && (int'(cell_address) < FRAME_CELLS);
   assign ram_wr_addr = fill_ff ? (ADDR_W'(cell_address) + FRAME_BASE)
                                : ADDR_W'(cell_address);
   assign ram_wr_data = char_value;

   // prefetch the byte at the next read position
   assign rd_idx      = (idx_in < END_IDX) ? idx_in : LAST_IDX;
   assign ram_rd_addr = disp_in ? (ADDR_W'(rd_idx) + FRAME_BASE) : ADDR_W'(rd_idx);

   // response item
   always_comb begin
      rsp_item.accepted     = is_tick || ((is_write || is_commit) && fill_free);
      rsp_item.rs_line      = rs_in;
      rsp_item.enable_line  = en_in;
      rsp_item.data_nibble  = data_in;
      rsp_item.tick_period  = rate_in ? busy_period_ff : idle_period_ff;
      rsp_item.refresh_busy = (state_in != SEQ_IDLE);
   end

endmodule

@@ rtl/core/cldb_rsp_queue.sv @@
// Two-entry response queue; decouples request intake from response stalls.
module cldb_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cldb_pkg::rsp_item_type push_item,
   output logic                   full,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cldb_pkg::rsp_item_type out_item
);
   import cldb_pkg::*;

   rsp_item_type slot0_ff, slot0_in;
   rsp_item_type slot1_ff, slot1_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign out_item  = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (push && !pop) begin
         if (count_ff == 2'd0) begin
            slot0_in = push_item;
         end else begin
            slot1_in = push_item;
         end
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end else if (pop && push) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_item;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

@@ rtl/core/char_lcd_double_buffer_refresh.sv @@
// Channel  Dir  Handshake            Payload
// req_chan in   valid/ready          op, cell_address, char_value
// rsp_chan out  valid/ready          accepted, rs_line, enable_line, data_nibble,
//                                    tick_period, refresh_busy
// csr_chan in   valid/ready (ready=1) index, data
//
// One request is taken per cycle while req_chan.ready is high; its response item is queued.
// The frame byte for a data tick is prefetched from the frame RAM.
// Responses sit in a two-entry queue; req_chan.ready drops only while it is full.
// Synchronous reset; no clearing pass, frame contents are undefined until written.
module char_lcd_double_buffer_refresh #(
   parameter int ROWS = 4,
   parameter int COLS = 20
) (
   input  logic        clock,
   input  logic        reset,
   cldb_req_if.sink    req_chan,
   cldb_rsp_if.source  rsp_chan,
   cldb_csr_if.sink    csr_chan
);
   import cldb_pkg::*;

   localparam int ADDR_W = $clog2(2 * ROWS * COLS);

   logic              req_fire;
   logic              queue_full;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;
   rsp_item_type      seq_item;
   rsp_item_type      out_item;

   // handshakes
   assign req_chan.ready = ~queue_full;
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;

   cldb_frame_ram #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cldb_seq #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .op           (req_chan.op),
      .cell_address (req_chan.cell_address),
      .char_value   (req_chan.char_value),
      .csr_we       (csr_chan.valid),
      .csr_index    (csr_chan.index),
      .csr_data     (csr_chan.data),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .rsp_item     (seq_item)
   );

   cldb_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_item (seq_item),
      .full      (queue_full),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   // response payload
   assign rsp_chan.accepted     = out_item.accepted;
   assign rsp_chan.rs_line      = out_item.rs_line;
   assign rsp_chan.enable_line  = out_item.enable_line;
   assign rsp_chan.data_nibble  = out_item.data_nibble;
   assign rsp_chan.tick_period  = out_item.tick_period;
   assign rsp_chan.refresh_busy = out_item.refresh_busy;

endmodule

@@ rtl/core/cldb_checker.sv @@
`include "char_lcd_double_buffer_refresh_macros.svh"

// Port-level checks on the refresh block.
module cldb_checker (
   input logic        clock,
   input logic        reset,
   cldb_req_if.sink   req_chan,
   cldb_rsp_if.source rsp_chan
);

   // response queue starts empty
   `CLDB_ASSERT_IMPLY(a_empty_after_reset, $past(reset), !rsp_chan.valid)

   // nothing waiting means room for a request
   `CLDB_ASSERT_IMPLY(a_ready_when_empty, !rsp_chan.valid, req_chan.ready)

   // strobe and command mode only occur inside a refresh
   `CLDB_ASSERT_IMPLY(a_strobe_in_refresh, rsp_chan.valid && rsp_chan.enable_line,
                      rsp_chan.refresh_busy)
   `CLDB_ASSERT_IMPLY(a_cmd_in_refresh, rsp_chan.valid && !rsp_chan.rs_line,
                      rsp_chan.refresh_busy)

   // stalled response holds
   `CLDB_ASSERT_NEXT(a_rsp_hold, rsp_chan.valid && !rsp_chan.ready,
                     rsp_chan.valid && $stable(rsp_chan.data_nibble))

endmodule

bind char_lcd_double_buffer_refresh cldb_checker u_cldb_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
